// ----- sv/capture_period_frequency_meter_assert.svh -----
// ----------------------------------------------------------------------------
// Capture period frequency meter assertion macros
// Property shorthands shared by the checker of the frequency meter.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_PERIOD_FREQUENCY_METER_ASSERT_SVH
`define CAPTURE_PERIOD_FREQUENCY_METER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPFM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CPFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Checked also while reset is applied.
`define CPFM_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/cpfm_pkg.sv -----
// ----------------------------------------------------------------------------
// Capture period frequency meter package
// Widths, reset values and shared types of the frequency meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpfm_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int RATE_WIDTH  = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);
    localparam int STEP_WIDTH  = $clog2(RATE_WIDTH);

    localparam logic [RATE_WIDTH-1:0] RATE_RESET = RATE_WIDTH'(1000000);
    localparam logic [RATE_WIDTH-1:0] FREQ_MAX   = {RATE_WIDTH{1'b1}};

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [RATE_WIDTH-1:0]  rate_t;

    typedef struct packed {
        logic   valid;
        count_t period;
    } period_req_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage

// ----- sv/cpfm_front.sv -----
// ----------------------------------------------------------------------------
// Capture period frequency meter front end
// Pairs capture edges and forms the period of each completed pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpfm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cpfm_pkg::count_t     capture_count,
    input  logic                 queue_full,
    output logic                 full,
    output cpfm_pkg::period_req_t period_req
);
    import cpfm_pkg::*;

    logic   accept;
    logic   pending_reg;
    logic   pending_next;
    count_t first_reg;

    assign full   = queue_full;
    assign accept = push && !full;

    assign pending_next      = accept ? !pending_reg : pending_reg;
    assign period_req.valid  = accept && pending_reg;
    assign period_req.period = capture_count - first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            first_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (accept && !pending_reg)
            begin
                first_reg <= capture_count;
            end
        end
    end

endmodule

// ----- sv/cpfm_queue.sv -----
// ----------------------------------------------------------------------------
// Capture period frequency meter period queue
// Short queue of periods between the front end and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpfm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cpfm_pkg::period_req_t wr_req,
    input  logic                  rd_pop,
    output cpfm_pkg::period_req_t head,
    output logic                  queue_full
);
    import cpfm_pkg::*;

    count_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QCNT_WIDTH-1:0] count_reg;
    logic [QCNT_WIDTH-1:0] count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign queue_full  = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign head.valid  = (count_reg != '0);
    assign head.period = slot_reg[rd_ptr_reg];

    assign do_wr = wr_req.valid && !queue_full;
    assign do_rd = rd_pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_req.period;
        end
    end

endmodule

// ----- sv/cpfm_divider.sv -----
// ----------------------------------------------------------------------------
// Capture period frequency meter divider
// Serial restoring divide of the tick rate by the period, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpfm_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  cpfm_pkg::rate_t       tick_rate,
    input  cpfm_pkg::period_req_t head,
    output logic                  rd_pop,
    input  logic                  pop,
    output logic                  empty,
    output cpfm_pkg::rate_t       frequency_hz,
    output logic                  zero_period
);
    import cpfm_pkg::*;

    div_state_t            state_reg;
    div_state_t            state_next;
    rate_t                 rate_reg;
    rate_t                 quo_reg;
    count_t                rem_reg;
    count_t                divisor_reg;
    logic [STEP_WIDTH-1:0] step_reg;
    logic                  zp_work_reg;
    rate_t                 freq_reg;
    logic                  zp_reg;
    logic                  valid_reg;
    logic                  start;
    logic                  load_res;
    logic                  last_step;
    logic [COUNT_WIDTH:0]  trial;

    assign trial     = {rem_reg, quo_reg[RATE_WIDTH-1]} - {1'b0, divisor_reg};
    assign last_step = (step_reg == STEP_WIDTH'(RATE_WIDTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        start      = 1'b0;
        load_res   = 1'b0;
        case (state_reg)
            DIV_IDLE:
            begin
                if (head.valid)
                begin
                    start      = 1'b1;
                    state_next = (head.period == '0) ? DIV_DONE : DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (last_step)
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (!valid_reg || pop)
                begin
                    load_res   = 1'b1;
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    assign rd_pop = start;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= head.period;
            rem_reg     <= '0;
            step_reg    <= '0;
            if (head.period == '0)
            begin
                quo_reg     <= FREQ_MAX;
                zp_work_reg <= 1'b1;
            end
            else
            begin
                quo_reg     <= rate_reg;
                zp_work_reg <= 1'b0;
            end
        end
        else if (state_reg == DIV_RUN)
        begin
            step_reg <= step_reg + 1'b1;
            if (!trial[COUNT_WIDTH])
            begin
                rem_reg <= trial[COUNT_WIDTH-1:0];
                quo_reg <= {quo_reg[RATE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[COUNT_WIDTH-2:0], quo_reg[RATE_WIDTH-1]};
                quo_reg <= {quo_reg[RATE_WIDTH-2:0], 1'b0};
            end
        end
        if (load_res)
        begin
            freq_reg <= quo_reg;
            zp_reg   <= zp_work_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                rate_reg <= tick_rate;
            end
            if (load_res)
            begin
                valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign empty        = !valid_reg;
    assign frequency_hz = freq_reg;
    assign zero_period  = zp_reg;

endmodule

// ----- sv/capture_period_frequency_meter.sv -----
// ----------------------------------------------------------------------------
// Capture period frequency meter
// Turns pairs of timer capture counts into a frequency in Hz.
// ----------------------------------------------------------------------------
// Each request on the input carries the timer count latched at one rising
// edge. Requests are taken in pairs: the first count of a pair is stored, the
// second forms the period modulo 2^16 and yields one result. A request is
// taken at a clock edge with push high and full low.
// The result, tick_rate divided by the period and truncated, waits on
// frequency_hz while empty is low and leaves at an edge with pop high. Equal
// counts give all ones and set zero_period.
// tick_rate is written through cfg_write; it resets to 1000000.
// The serial divider handles one period at a time, one quotient bit per cycle
// over 24 bits, plus load and write-back; equal counts skip the bit steps.
// A two-entry period queue lets the front accept requests while the divider
// works; full rises only once both entries are taken. A stalled receiver
// holds the divider in its final state and then fills the queue.
// Reset empties the queue, clears the pairing state and sets empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module capture_period_frequency_meter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cpfm_pkg::count_t  capture_count,
    output logic              empty,
    input  logic              pop,
    output cpfm_pkg::rate_t   frequency_hz,
    output logic              zero_period,
    input  logic              cfg_write,
    input  cpfm_pkg::rate_t   tick_rate
);
    import cpfm_pkg::*;

    period_req_t wr_req;
    period_req_t head;
    logic        queue_full;
    logic        rd_pop;

    cpfm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .capture_count (capture_count),
        .queue_full    (queue_full),
        .full          (full),
        .period_req    (wr_req)
    );

    cpfm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_req     (wr_req),
        .rd_pop     (rd_pop),
        .head       (head),
        .queue_full (queue_full)
    );

    cpfm_divider u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .tick_rate    (tick_rate),
        .head         (head),
        .rd_pop       (rd_pop),
        .pop          (pop),
        .empty        (empty),
        .frequency_hz (frequency_hz),
        .zero_period  (zero_period)
    );

endmodule

// ----- sv/cpfm_checker.sv -----
// ----------------------------------------------------------------------------
// Capture period frequency meter checker
// Port-level properties of the frequency meter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "capture_period_frequency_meter_assert.svh"

module cpfm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input cpfm_pkg::rate_t   frequency_hz,
    input logic              zero_period
);
    import cpfm_pkg::*;

    `CPFM_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop,
        !empty && $stable(frequency_hz) && $stable(zero_period))
    `CPFM_ASSERT_SAME(a_zero_saturates, clk, rst_n, !empty && zero_period,
        frequency_hz == FREQ_MAX)
    `CPFM_ASSERT_RESET(a_reset_clears, clk, !rst_n, empty && !full)

endmodule

bind capture_period_frequency_meter cpfm_checker u_cpfm_checker (.*);
